/* hdl/lsl_pkg.sv */
// ----------------------------------------------------------------------------
// lsl_pkg: shared types and constants for the lux calculation pipeline
// Holds the sample record that travels with each item, the clip thresholds,
// scale factors, segment bounds and coefficients, and the ROM root helper.
// ----------------------------------------------------------------------------
package lsl_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_INTEG = 2'd0;
  localparam logic [1:0] CFG_GAIN  = 2'd1;

  // Integration time codes; any other code acts as 402 ms.
  localparam logic [1:0] INTEG_13MS  = 2'd0;
  localparam logic [1:0] INTEG_101MS = 2'd1;
  localparam logic [1:0] INTEG_402MS = 2'd2;

  // Clip thresholds.
  localparam logic [15:0] THR_13MS  = 16'd4900;
  localparam logic [15:0] THR_101MS = 16'd37000;
  localparam logic [15:0] THR_402MS = 16'd65000;

  // Scale factors to the 402 ms equivalent, Q.16.
  localparam int SCALE_W = 21;
  localparam logic [SCALE_W-1:0] SCALE_13MS  = 21'd1923027;
  localparam logic [SCALE_W-1:0] SCALE_101MS = 21'd260846;
  localparam logic [SCALE_W-1:0] SCALE_402MS = 21'd65536;

  // Ratio is Q2.16, saturated at 2.0.
  localparam int RATIO_W = 18;
  localparam logic [RATIO_W-1:0] RATIO_SAT = 18'd131072;

  // Divider pipeline shape: quotient bits resolved per stage.
  localparam int DIV_STEPS  = 3;
  localparam int DIV_STAGES = RATIO_W / DIV_STEPS;

  // Segment codes; the pow segment uses the ROM, the last code gives zero.
  localparam logic [2:0] SEG_POW  = 3'd0;
  localparam logic [2:0] SEG_NONE = 3'd7;

  localparam int COEF_W = 20;
  localparam logic [RATIO_W-1:0] SEG_BOUND [7] = '{
    18'd8192, 18'd16384, 18'd24576, 18'd32768, 18'd39976, 18'd52428, 18'd85196
  };
  // Entry SEG_NONE is zero so that segment yields no light.
  localparam logic [COEF_W-1:0] SEG_A [8] = '{
    20'd510027, 20'd375810, 20'd214748, 20'd24495, 20'd5369, 20'd3020, 20'd1007, 20'd0
  };
  localparam logic [COEF_W-1:0] SEG_B [8] = '{
    20'd1040187, 20'd520094, 20'd256691, 20'd18790, 20'd4362, 20'd2517, 20'd839, 20'd0
  };

  localparam longint unsigned POW_C = 64'd3566;

  // One item as it moves down the pipe.
  typedef struct packed {
    logic [15:0] ch0;
    logic [15:0] ch1;
    logic        sat;
  } samp_t;

  // Integer fifth root by binary search; used only to build the ROM.
  function automatic longint unsigned fifth_root(input longint unsigned q);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned p;
    lo = 0;
    hi = 4096;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      p = mid * mid * mid * mid * mid;
      if (p <= q) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    return lo;
  endfunction

endpackage

/* hdl/lsl_div.sv */
// ----------------------------------------------------------------------------
// lsl_div: pipelined infrared/broadband ratio divider
// Restoring division of ch1 * 2^16 by ch0, a few quotient bits per stage,
// with the ratio saturated at 2.0 and forced to zero for a zero divisor.
// ----------------------------------------------------------------------------
module lsl_div
  import lsl_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_valid,
  input  samp_t              in_samp,
  output logic               out_valid,
  output samp_t              out_samp,
  output logic [RATIO_W-1:0] out_ratio
);

  // Stage source values (stage 0 takes the input) and stage registers.
  logic               src_v    [DIV_STAGES];
  samp_t              src_samp [DIV_STAGES];
  logic [15:0]        src_rem  [DIV_STAGES];
  logic [RATIO_W-1:0] src_q    [DIV_STAGES];
  logic               src_zero [DIV_STAGES];
  logic               src_big  [DIV_STAGES];

  logic               v_r      [DIV_STAGES];
  samp_t              samp_r   [DIV_STAGES];
  logic [15:0]        rem_r    [DIV_STAGES];
  logic [RATIO_W-1:0] q_r      [DIV_STAGES];
  logic               zero_r   [DIV_STAGES];
  logic               big_r    [DIV_STAGES];

  logic [15:0]        rem_nxt  [DIV_STAGES];
  logic [RATIO_W-1:0] q_nxt    [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    // Source selection: the input for the first stage, else the stage before.
    if (s == 0) begin : g_first
      // Quotient bits above 17 are zero once ch1 < 2*ch0, so start at ch1 >> 2.
      assign src_v[s]    = in_valid;
      assign src_samp[s] = in_samp;
      assign src_rem[s]  = {2'b00, in_samp.ch1[15:2]};
      assign src_q[s]    = '0;
      assign src_zero[s] = (in_samp.ch0 == 16'd0);
      assign src_big[s]  = ({1'b0, in_samp.ch1} >= {in_samp.ch0, 1'b0});
    end else begin : g_next
      assign src_v[s]    = v_r[s-1];
      assign src_samp[s] = samp_r[s-1];
      assign src_rem[s]  = rem_r[s-1];
      assign src_q[s]    = q_r[s-1];
      assign src_zero[s] = zero_r[s-1];
      assign src_big[s]  = big_r[s-1];
    end

    // Shift-subtract steps for this stage's quotient bits.
    always_comb begin
      logic [RATIO_W-1:0] dlow;
      logic [16:0]        trial;
      int                 bitpos;
      dlow = {src_samp[s].ch1[1:0], 16'd0};
      rem_nxt[s] = src_rem[s];
      q_nxt[s]   = src_q[s];
      for (int j = 0; j < DIV_STEPS; j++) begin
        bitpos = RATIO_W - 1 - s * DIV_STEPS - j;
        trial  = {rem_nxt[s], dlow[bitpos]};
        if (trial >= {1'b0, src_samp[s].ch0}) begin
          rem_nxt[s]       = 16'(trial - {1'b0, src_samp[s].ch0});
          q_nxt[s][bitpos] = 1'b1;
        end else begin
          rem_nxt[s] = trial[15:0];
        end
      end
    end

    // Stage register.
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (adv) begin
        v_r[s] <= src_v[s];
      end
      if (adv) begin
        samp_r[s] <= src_samp[s];
        rem_r[s]  <= rem_nxt[s];
        q_r[s]    <= q_nxt[s];
        zero_r[s] <= src_zero[s];
        big_r[s]  <= src_big[s];
      end
    end
  end

  // Final ratio with the zero-divisor and saturation overrides.
  assign out_valid = v_r[DIV_STAGES-1];
  assign out_samp  = samp_r[DIV_STAGES-1];
  assign out_ratio = zero_r[DIV_STAGES-1] ? '0 :
                     big_r[DIV_STAGES-1]  ? RATIO_SAT : q_r[DIV_STAGES-1];

`ifndef ASSERT_OFF
  // The ratio never exceeds its saturation value.
  a_ratio_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_ratio <= RATIO_SAT)
    else $error("ratio above saturation");
  // A zero divisor always yields a zero ratio.
  a_zero_div: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_samp.ch0 == 16'd0) |-> out_ratio == '0)
    else $error("nonzero ratio for zero broadband count");
  // For a nonzero divisor and an unsaturated ratio, the remainder ends below the divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !zero_r[DIV_STAGES-1] && !big_r[DIV_STAGES-1])
      |-> rem_r[DIV_STAGES-1] < out_samp.ch0)
    else $error("divider remainder out of range");
`endif

endmodule

/* hdl/lsl_seg.sv */
// ----------------------------------------------------------------------------
// lsl_seg: segment selection and coefficient stages
// Picks the linear segment from the ratio, looks up ratio^1.4 in the pow ROM
// for the first segment, and delivers the two channel coefficients.
// ----------------------------------------------------------------------------
module lsl_seg
  import lsl_pkg::*;
#(
  parameter int POW_TABLE_DEPTH = 64
)
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_valid,
  input  samp_t              in_samp,
  input  logic [RATIO_W-1:0] in_ratio,
  output logic               out_valid,
  output samp_t              out_samp,
  output logic [COEF_W-1:0]  out_ca,
  output logic [COEF_W-1:0]  out_cb
);

  localparam int IDX_W  = $clog2(POW_TABLE_DEPTH);
  localparam int LAST   = POW_TABLE_DEPTH - 1;
  localparam int PROD_W = 14 + IDX_W + 1;
  localparam int FULL_W = PROD_W - 13;
  localparam int BP_W   = COEF_W + 16;

  // Pow ROM, built at elaboration: 2^16 * (0.125*t)^1.4 for t = k/LAST.
  logic [15:0] rom_w [POW_TABLE_DEPTH];
  for (genvar k = 0; k < POW_TABLE_DEPTH; k++) begin : g_rom
    localparam longint unsigned AK = (longint'(k) << 30) / LAST;
    localparam longint unsigned WK = fifth_root(AK * AK);
    localparam longint unsigned RK = (longint'(k) * POW_C * WK) / (longint'(LAST) << 12);
    assign rom_w[k] = 16'(RK);
  end

  // Stage A: segment search and ROM index.
  logic [2:0]        seg_nxt;
  logic [PROD_W-1:0] prod;
  logic [FULL_W-1:0] idx_full;
  logic [IDX_W-1:0]  idx_nxt;

  always_comb begin
    seg_nxt = SEG_NONE;
    for (int i = 6; i >= 0; i--) begin
      if (in_ratio <= SEG_BOUND[i]) begin
        seg_nxt = 3'(i);
      end
    end
    prod     = PROD_W'(in_ratio[13:0]) * PROD_W'(LAST) + PROD_W'(4096);
    idx_full = prod[PROD_W-1:13];
    if (idx_full > FULL_W'(LAST)) begin
      idx_nxt = IDX_W'(LAST);
    end else begin
      idx_nxt = idx_full[IDX_W-1:0];
    end
  end

  logic             va_r;
  samp_t            sampa_r;
  logic [2:0]       sega_r;
  logic [IDX_W-1:0] idxa_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_valid;
    end
    if (adv) begin
      sampa_r <= in_samp;
      sega_r  <= seg_nxt;
      idxa_r  <= idx_nxt;
    end
  end

  // Stage B: ROM read and B0 * ratio^1.4 product.
  logic            vb_r;
  samp_t           sampb_r;
  logic [2:0]      segb_r;
  logic [BP_W-1:0] bp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (adv) begin
      vb_r <= va_r;
    end
    if (adv) begin
      sampb_r <= sampa_r;
      segb_r  <= sega_r;
      bp_r    <= BP_W'(SEG_B[SEG_POW]) * BP_W'(rom_w[idxa_r]);
    end
  end

  // Stage C: coefficient selection.
  logic [COEF_W-1:0] ca_nxt;
  logic [COEF_W-1:0] cb_nxt;

  always_comb begin
    if (segb_r == SEG_POW) begin
      ca_nxt = SEG_A[SEG_POW] - bp_r[BP_W-1:16];
      cb_nxt = '0;
    end else begin
      ca_nxt = SEG_A[segb_r];
      cb_nxt = SEG_B[segb_r];
    end
  end

  logic              vc_r;
  samp_t             sampc_r;
  logic [COEF_W-1:0] ca_r;
  logic [COEF_W-1:0] cb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (adv) begin
      vc_r <= vb_r;
    end
    if (adv) begin
      sampc_r <= sampb_r;
      ca_r    <= ca_nxt;
      cb_r    <= cb_nxt;
    end
  end

  assign out_valid = vc_r;
  assign out_samp  = sampc_r;
  assign out_ca    = ca_r;
  assign out_cb    = cb_r;

`ifndef ASSERT_OFF
  // The pow segment never uses the infrared coefficient.
  a_pow_cb: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && vb_r && segb_r == SEG_POW) |=> cb_r == '0)
    else $error("pow segment with infrared coefficient");
  // Ratios above the top bound give no coefficients at all.
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && vb_r && segb_r == SEG_NONE) |=> (ca_r == '0 && cb_r == '0))
    else $error("coefficients for out-of-range ratio");
  // The pow segment index comes from a ratio in the first segment.
  a_pow_ratio: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && in_valid && seg_nxt == SEG_POW) |-> in_ratio <= SEG_BOUND[0])
    else $error("pow segment outside its bound");
`endif

endmodule

/* hdl/lsl_lux.sv */
// ----------------------------------------------------------------------------
// lsl_lux: channel combination, scaling and output register
// Forms ca*ch0 - cb*ch1, clamps it at zero, scales it to the 402 ms
// equivalent in split partial products, shifts to the lux format and saturates.
// ----------------------------------------------------------------------------
module lsl_lux
  import lsl_pkg::*;
#(
  parameter int LUX_FRAC_BITS = 8
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic [1:0]        integ,
  input  logic              gain,
  input  logic              in_valid,
  input  samp_t             in_samp,
  input  logic [COEF_W-1:0] in_ca,
  input  logic [COEF_W-1:0] in_cb,
  output logic              out_valid,
  output logic [20:0]       out_lux_value,
  output logic              out_saturated
);

  localparam int P_W   = COEF_W + 16;
  localparam int HALF  = P_W / 2;
  localparam int PP_W  = HALF + SCALE_W;
  localparam int SUM_W = P_W + SCALE_W + 1;
  localparam int SH_LO = 40 - LUX_FRAC_BITS;
  localparam int SH_HI = SH_LO + 4;
  localparam logic [SUM_W-1:0] LUX_MAX = SUM_W'(21'h1FFFFF);

  // Stage D: channel products.
  logic           vd_r;
  logic           satd_r;
  logic [P_W-1:0] pa_r;
  logic [P_W-1:0] pb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (adv) begin
      vd_r <= in_valid;
    end
    if (adv) begin
      satd_r <= in_samp.sat;
      pa_r   <= P_W'(in_ca) * P_W'(in_samp.ch0);
      pb_r   <= P_W'(in_cb) * P_W'(in_samp.ch1);
    end
  end

  // Stage E: difference and positive test.
  logic           ve_r;
  logic           sate_r;
  logic           pose_r;
  logic [P_W-1:0] dp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else if (adv) begin
      ve_r <= vd_r;
    end
    if (adv) begin
      sate_r <= satd_r;
      pose_r <= (pa_r > pb_r);
      dp_r   <= pa_r - pb_r;
    end
  end

  // Stage F: scale factor times the two halves of the difference.
  logic [SCALE_W-1:0] scale;

  always_comb begin
    case (integ)
      INTEG_13MS:  scale = SCALE_13MS;
      INTEG_101MS: scale = SCALE_101MS;
      default:     scale = SCALE_402MS;
    endcase
  end

  logic            vf_r;
  logic            satf_r;
  logic            posf_r;
  logic [PP_W-1:0] lo_r;
  logic [PP_W-1:0] hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (adv) begin
      vf_r <= ve_r;
    end
    if (adv) begin
      satf_r <= sate_r;
      posf_r <= pose_r;
      lo_r   <= PP_W'(dp_r[HALF-1:0]) * PP_W'(scale);
      hi_r   <= PP_W'(dp_r[P_W-1:HALF]) * PP_W'(scale);
    end
  end

  // Stage G: recombine, shift to the lux format and saturate.
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] shifted;
  logic [20:0]      lux_nxt;

  always_comb begin
    sum     = (SUM_W'(hi_r) << HALF) + SUM_W'(lo_r);
    shifted = gain ? (sum >> SH_HI) : (sum >> SH_LO);
    if (satf_r || !posf_r) begin
      lux_nxt = '0;
    end else if (shifted > LUX_MAX) begin
      lux_nxt = 21'h1FFFFF;
    end else begin
      lux_nxt = shifted[20:0];
    end
  end

  logic        out_valid_r;
  logic [20:0] out_lux_value_r;
  logic        out_saturated_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vf_r;
    end
    if (adv) begin
      out_lux_value_r <= lux_nxt;
      out_saturated_r <= satf_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_lux_value = out_lux_value_r;
  assign out_saturated = out_saturated_r;

`ifndef ASSERT_OFF
  // A non-positive difference always reports zero light.
  a_neg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && vf_r && !posf_r) |=> out_lux_value == '0)
    else $error("light reported for non-positive difference");
  // A set positive flag implies a nonzero stored difference.
  a_pos_nz: assert property (@(posedge clk) disable iff (!rst_n)
    (ve_r && pose_r) |-> dp_r != '0)
    else $error("positive flag with zero difference");
  // The saturation flag follows the item through the last stage.
  a_sat_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && vf_r) |=> out_saturated == $past(satf_r))
    else $error("saturation flag lost");
`endif

endmodule

/* hdl/light_sensor_lux_calculation.sv */
// ----------------------------------------------------------------------------
// light_sensor_lux_calculation: two-channel light sensor lux calculation
// Throughput: one item per cycle while no finished result is held; the
// 18-step ratio divider is pipelined over six stages, and the multiplies
// are spread over stages A, B, D and F.
// Stalls hold the whole pipe; in_ready is low only while a result waits.
// Reset (synchronous, active low) empties the pipe and sets 402 ms, 1x gain.
// ----------------------------------------------------------------------------
module light_sensor_lux_calculation
  import lsl_pkg::*;
#(
  parameter int POW_TABLE_DEPTH = 64,
  parameter int LUX_FRAC_BITS   = 8
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_broadband_count,
  input  logic [15:0] in_infrared_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] out_lux_value,
  output logic        out_saturated,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [1:0]  cfg_data
);

  // Configuration registers.
  logic [1:0] integ_r;
  logic       gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= INTEG_402MS;
      gain_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INTEG: integ_r <= cfg_data;
        CFG_GAIN:  gain_r  <= cfg_data[0];
        default:   ;
      endcase
    end
  end

  // The whole pipe advances unless a finished result is held.
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Input stage with the clip test.
  logic [15:0] thr;

  always_comb begin
    case (integ_r)
      INTEG_13MS:  thr = THR_13MS;
      INTEG_101MS: thr = THR_101MS;
      default:     thr = THR_402MS;
    endcase
  end

  logic  s0_valid_r;
  samp_t s0_samp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (adv) begin
      s0_valid_r <= in_valid;
    end
    if (adv) begin
      s0_samp_r.ch0 <= in_broadband_count;
      s0_samp_r.ch1 <= in_infrared_count;
      s0_samp_r.sat <= (in_broadband_count >= thr) || (in_infrared_count >= thr);
    end
  end

  // Ratio divider.
  logic               div_valid;
  samp_t              div_samp;
  logic [RATIO_W-1:0] div_ratio;

  lsl_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (s0_valid_r),
    .in_samp   (s0_samp_r),
    .out_valid (div_valid),
    .out_samp  (div_samp),
    .out_ratio (div_ratio)
  );

  // Segment and coefficient stages.
  logic              seg_valid;
  samp_t             seg_samp;
  logic [COEF_W-1:0] seg_ca;
  logic [COEF_W-1:0] seg_cb;

  lsl_seg #(
    .POW_TABLE_DEPTH (POW_TABLE_DEPTH)
  ) u_seg (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (div_valid),
    .in_samp   (div_samp),
    .in_ratio  (div_ratio),
    .out_valid (seg_valid),
    .out_samp  (seg_samp),
    .out_ca    (seg_ca),
    .out_cb    (seg_cb)
  );

  // Combination, scaling and output register.
  lsl_lux #(
    .LUX_FRAC_BITS (LUX_FRAC_BITS)
  ) u_lux (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .integ         (integ_r),
    .gain          (gain_r),
    .in_valid      (seg_valid),
    .in_samp       (seg_samp),
    .in_ca         (seg_ca),
    .in_cb         (seg_cb),
    .out_valid     (out_valid),
    .out_lux_value (out_lux_value),
    .out_saturated (out_saturated)
  );

`ifndef ASSERT_OFF
  // A saturated item never carries light.
  a_sat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |-> out_lux_value == '0)
    else $error("saturated item with nonzero lux");
  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
  // A held result blocks new items.
  a_hold_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("item taken while result held");
`endif

endmodule

/* tb/sv/light_sensor_lux_calculation_test.sv */
// ----------------------------------------------------------------------------
// light_sensor_lux_calculation_test: self-checking bench for the lux pipeline
// Drives broadband/infrared count pairs through the valid/ready handshake
// under several idling phases and integration/gain settings, and checks each
// result against an in-bench lux predictor or a typed-in expected value.
// ----------------------------------------------------------------------------
module light_sensor_lux_calculation_test
  import lsl_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROM_DEPTH = 64;
  localparam int FRAC_BITS = 8;
  localparam int PIPE_LAT  = 14;
  localparam longint unsigned CYCLE_LIMIT = 400000;
  localparam int N_DIRECTED = 22;
  // A register index that names no register; writes to it are ignored.
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [20:0] lux;
    logic        sat;
  } lux_res_t;

  // One row of the directed table; check_lux set means lux_want is typed in.
  typedef struct packed {
    logic [15:0] ch0;
    logic [15:0] ch1;
    logic        check_lux;
    logic [20:0] lux_want;
    logic        sat_want;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] in_broadband_count;
  logic [15:0] in_infrared_count;
  logic        out_valid;
  logic        out_ready;
  logic [20:0] out_lux_value;
  logic        out_saturated;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [1:0]  cfg_data;

  logic [1:0]  integ_sel;
  logic        gain_hi;
  longint unsigned pow_tab [ROM_DEPTH];
  lux_res_t    lux_queue [$];
  int          mismatches;
  longint unsigned cycles;
  int          send_idle_pct;
  int          recv_stall_pct;

  light_sensor_lux_calculation i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_broadband_count (in_broadband_count),
    .in_infrared_count  (in_infrared_count),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_lux_value      (out_lux_value),
    .out_saturated      (out_saturated),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Integer fifth root by bisection, for the power table.
  function automatic longint unsigned root5(input longint unsigned q);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    lo = 0;
    hi = 4096;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (mid * mid * mid * mid * mid <= q) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // Fill the ratio^1.4 table.
  initial begin
    longint unsigned a;
    for (int k = 0; k < ROM_DEPTH; k++) begin
      a = (longint'(k) << 30) / (ROM_DEPTH - 1);
      pow_tab[k] = (longint'(k) * 3566 * root5(a * a)) / (longint'(ROM_DEPTH - 1) << 12);
    end
  end

  // Expected lux for one count pair under the current settings.
  function automatic lux_res_t predict_lux(input logic [15:0] ch0, input logic [15:0] ch1);
    lux_res_t r;
    longint unsigned thr;
    longint unsigned scale;
    longint unsigned ratio;
    longint unsigned idx;
    longint unsigned lux;
    longint d;
    int seg;
    r = '0;
    case (integ_sel)
      INTEG_13MS: begin
        thr = THR_13MS;
        scale = SCALE_13MS;
      end
      INTEG_101MS: begin
        thr = THR_101MS;
        scale = SCALE_101MS;
      end
      default: begin
        thr = THR_402MS;
        scale = SCALE_402MS;
      end
    endcase
    if (ch0 >= thr || ch1 >= thr) begin
      r.sat = 1'b1;
      return r;
    end
    ratio = 0;
    if (ch0 != 0) begin
      ratio = (longint'(ch1) << 16) / ch0;
      if (ratio > RATIO_SAT) ratio = RATIO_SAT;
    end
    seg = SEG_NONE;
    for (int i = 6; i >= 0; i--)
      if (ratio <= SEG_BOUND[i]) seg = i;
    if (seg == SEG_NONE) begin
      d = 0;
    end else if (seg == SEG_POW) begin
      idx = (ratio * (ROM_DEPTH - 1) + 4096) >> 13;
      if (idx > ROM_DEPTH - 1) idx = ROM_DEPTH - 1;
      d = (longint'(SEG_A[0]) - ((longint'(SEG_B[0]) * longint'(pow_tab[idx])) >>> 16))
          * longint'(ch0);
    end else begin
      d = longint'(SEG_A[seg]) * ch0 - longint'(SEG_B[seg]) * ch1;
    end
    if (d > 0) begin
      lux = (longint'(d) * scale) >> (40 - FRAC_BITS + (gain_hi ? 4 : 0));
      r.lux = (lux > 21'h1FFFFF) ? 21'h1FFFFF : lux[20:0];
    end
    return r;
  endfunction

  // Register write, issued only while the pipe is empty.
  task automatic write_reg(input logic [1:0] index, input logic [1:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = index;
    cfg_data = value;
    if (index == CFG_INTEG) integ_sel = value;
    else if (index == CFG_GAIN) gain_hi = value[0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic wait_drained();
    while (lux_queue.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 4) @(negedge clk);
  endtask

  // Present one item and hold it until accepted; push its expected result.
  task automatic send_pair(input logic [15:0] ch0, input logic [15:0] ch1,
                           input logic use_want, input lux_res_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_broadband_count = ch0;
    in_infrared_count = ch1;
    lux_queue.push_back(use_want ? want : predict_lux(ch0, ch1));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Random counts: mostly below the clip threshold, often with a near ratio.
  task automatic send_random();
    logic [15:0] ch0;
    logic [15:0] ch1;
    int mode;
    mode = int'($urandom_range(9));
    ch0 = 16'($urandom);
    ch1 = 16'($urandom);
    if (mode < 5) begin
      ch0 = 16'($urandom_range(integ_sel == INTEG_13MS ? 4899 : 36999));
      ch1 = 16'((longint'(ch0) * $urandom_range(1400)) / 1000);
    end else if (mode < 7) begin
      ch0 = 16'($urandom_range(300));
      ch1 = 16'($urandom_range(300));
    end
    send_pair(ch0, ch1, 1'b0, '0);
  endtask

  // Receiver stalls and result checking.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    lux_res_t want;
    cycles <= cycles + 1;
    if (rst_n && out_valid && out_ready) begin
      if (lux_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result lux=%0d", out_lux_value);
      end else begin
        want = lux_queue.pop_front();
        if (want.lux !== out_lux_value || want.sat !== out_saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: lux exp %0d got %0d, sat exp %0b got %0b",
                     want.lux, out_lux_value, want.sat, out_saturated);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  dir_row_t dir_tab [N_DIRECTED];

  initial begin
    // Directed rows at 402 ms, 1x gain.
    dir_tab = '{
      '{16'd0,     16'd0,     1'b1, 21'd0, 1'b0},   // zero counts
      '{16'd0,     16'd1000,  1'b1, 21'd0, 1'b0},   // zero broadband
      '{16'd65535, 16'd0,     1'b1, 21'd0, 1'b1},   // broadband clipped
      '{16'd0,     16'd65535, 1'b1, 21'd0, 1'b1},   // infrared clipped
      '{16'd65000, 16'd10,    1'b1, 21'd0, 1'b1},   // exactly at threshold
      '{16'd64999, 16'd64999, 1'b0, 21'd0, 1'b0},   // ratio 1.0 above 0.80 bound
      '{16'd1000,  16'd2000,  1'b1, 21'd0, 1'b0},   // ratio above 1.30
      '{16'd100,   16'd200,   1'b1, 21'd0, 1'b0},   // ratio 2.0
      '{16'd64999, 16'd0,     1'b0, 21'd0, 1'b0},   // ratio zero, pow segment
      '{16'd40000, 16'd4000,  1'b0, 21'd0, 1'b0},
      '{16'd40000, 16'd5000,  1'b0, 21'd0, 1'b0},   // on first bound
      '{16'd40000, 16'd8000,  1'b0, 21'd0, 1'b0},
      '{16'd40000, 16'd12000, 1'b0, 21'd0, 1'b0},
      '{16'd40000, 16'd16000, 1'b0, 21'd0, 1'b0},
      '{16'd40000, 16'd22000, 1'b0, 21'd0, 1'b0},
      '{16'd40000, 16'd28000, 1'b0, 21'd0, 1'b0},
      '{16'd40000, 16'd40000, 1'b0, 21'd0, 1'b0},
      '{16'd40000, 16'd50000, 1'b0, 21'd0, 1'b0},
      '{16'd1,     16'd1,     1'b0, 21'd0, 1'b0},
      '{16'd64999, 16'd64998, 1'b0, 21'd0, 1'b0},
      '{16'd21845, 16'd43690, 1'b0, 21'd0, 1'b0},
      '{16'd65534, 16'd1,     1'b1, 21'd0, 1'b1}
    };
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_broadband_count = '0;
    in_infrared_count = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    integ_sel = INTEG_402MS;
    gain_hi = 1'b0;
    mismatches = 0;
    cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[i])
      send_pair(dir_tab[i].ch0, dir_tab[i].ch1, dir_tab[i].check_lux,
                '{lux: dir_tab[i].lux_want, sat: dir_tab[i].sat_want});
    wait_drained();

    // Sixteen phases: every setting, including the unused code, and each idling mix.
    for (int ph = 0; ph < 16; ph++) begin
      write_reg(CFG_INTEG, 2'(ph % 4));
      write_reg(CFG_GAIN, 2'((ph / 4) % 2));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      if (ph % 4 == 0) send_idle_pct = (ph / 4) * 15;
      for (int n = 0; n < 80; n++) begin
        send_random();
        // Sender hold-off until everything already sent has come back.
        if (n == 40 && ph == 5) while (lux_queue.size() != 0) @(negedge clk);
      end
      wait_drained();
    end
    // Extreme high-gain short integration with directed extremes.
    write_reg(CFG_INTEG, INTEG_13MS);
    write_reg(CFG_GAIN, 2'd1);
    send_pair(16'd4899, 16'd0, 1'b0, '0);
    send_pair(16'd4900, 16'd0, 1'b1, '{lux: 21'd0, sat: 1'b1});
    wait_drained();
    write_reg(CFG_UNUSED, 2'd0);
    send_pair(16'd4899, 16'd100, 1'b0, '0);
    wait_drained();

    if (mismatches == 0 && lux_queue.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
